// ===== hw/rtl/gtc_pkg.sv =====
package gtc_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;
  localparam int NODE_W    = 6;
  localparam int EDGE_AW   = 8;
  localparam int TOT_W     = 9;
  localparam int CNT_W     = 7;
  localparam int RANK_W    = 3;
  localparam int WGT_W     = 16;
  localparam int THR_W     = 17;
  localparam int DIV_CW    = 5;

  typedef enum logic [4:0] {
    ST_LOAD, ST_SORT_I, ST_SORT_WI, ST_SORT_JA, ST_SORT_JC, ST_SORT_WR, ST_CLR,
    ST_K, ST_KE, ST_KC, ST_FA_RD, ST_FA_CHK, ST_FA_WR, ST_FA_INFO,
    ST_FB_RD, ST_FB_CHK, ST_FB_WR, ST_FB_INFO, ST_JUDGE, ST_DIV, ST_THR,
    ST_NEXT, ST_O_RD, ST_O_CHK, ST_O_WAIT
  } state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_RD_WI, OP_CAP_WI, OP_RD_WJ, OP_CMP, OP_ORD_WR, OP_CLR,
    OP_RD_ORD, OP_RD_EDGE, OP_CAP_EDGE, OP_WALK_RD, OP_WALK_CHK, OP_FA_WR,
    OP_FA_INFO, OP_FB_WR, OP_FB_INFO, OP_MERGE, OP_THR, OP_NEXT, OP_O_CHK,
    OP_O_WAIT
  } op_t;

  typedef enum logic {
    CFG_NODE_COUNT = 1'b0,
    CFG_SCALE_C    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic last_acc;
    logic j_last;
    logic i_last;
    logic clr_last;
    logic range_bad;
    logic is_root;
    logic judge_ok;
    logic div_done;
    logic k_last;
    logic o_last;
    logic out_acc;
  } status_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [CNT_W-1:0]  size;
    logic [THR_W-1:0]  thr;
  } info_t;

endpackage

// ===== hw/rtl/gtc_div.sv =====
module gtc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [6:0]  divisor,
  output logic        done,
  output logic [15:0] quotient
);
  import gtc_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]       q_r, q_nxt;
  logic [6:0]        rem_r, rem_nxt;
  logic [7:0]        trial;
  logic [7:0]        diff;

  assign trial = {rem_r, q_r[15]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CW'(WGT_W);
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[6:0];
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[6:0];
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== hw/rtl/gtc_ctrl.sv =====
module gtc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  gtc_pkg::status_t status,
  output gtc_pkg::cmd_t    cmd,
  output logic             in_stall
);
  import gtc_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:    if (status.last_acc) state_nxt = ST_SORT_I;
      ST_SORT_I:  state_nxt = ST_SORT_WI;
      ST_SORT_WI: state_nxt = ST_SORT_JA;
      ST_SORT_JA: state_nxt = ST_SORT_JC;
      ST_SORT_JC: state_nxt = status.j_last ? ST_SORT_WR : ST_SORT_JA;
      ST_SORT_WR: state_nxt = status.i_last ? ST_CLR : ST_SORT_I;
      ST_CLR:     if (status.clr_last) state_nxt = ST_K;
      ST_K:       state_nxt = ST_KE;
      ST_KE:      state_nxt = ST_KC;
      ST_KC:      state_nxt = status.range_bad ? ST_NEXT : ST_FA_RD;
      ST_FA_RD:   state_nxt = ST_FA_CHK;
      ST_FA_CHK:  state_nxt = status.is_root ? ST_FA_WR : ST_FA_RD;
      ST_FA_WR:   state_nxt = ST_FA_INFO;
      ST_FA_INFO: state_nxt = ST_FB_RD;
      ST_FB_RD:   state_nxt = ST_FB_CHK;
      ST_FB_CHK:  state_nxt = status.is_root ? ST_FB_WR : ST_FB_RD;
      ST_FB_WR:   state_nxt = ST_FB_INFO;
      ST_FB_INFO: state_nxt = ST_JUDGE;
      ST_JUDGE:   state_nxt = status.judge_ok ? ST_DIV : ST_NEXT;
      ST_DIV:     if (status.div_done) state_nxt = ST_THR;
      ST_THR:     state_nxt = ST_NEXT;
      ST_NEXT:    state_nxt = status.k_last ? ST_O_RD : ST_K;
      ST_O_RD:    state_nxt = ST_O_CHK;
      ST_O_CHK:   state_nxt = status.is_root ? ST_O_WAIT : ST_O_RD;
      ST_O_WAIT: begin
        if (status.out_acc) state_nxt = status.o_last ? ST_LOAD : ST_O_RD;
      end
      default:    state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd.op = OP_IDLE;
    case (state_r)
      ST_LOAD:    cmd.op = OP_LOAD;
      ST_SORT_I:  cmd.op = OP_RD_WI;
      ST_SORT_WI: cmd.op = OP_CAP_WI;
      ST_SORT_JA: cmd.op = OP_RD_WJ;
      ST_SORT_JC: cmd.op = OP_CMP;
      ST_SORT_WR: cmd.op = OP_ORD_WR;
      ST_CLR:     cmd.op = OP_CLR;
      ST_K:       cmd.op = OP_RD_ORD;
      ST_KE:      cmd.op = OP_RD_EDGE;
      ST_KC:      cmd.op = OP_CAP_EDGE;
      ST_FA_RD:   cmd.op = OP_WALK_RD;
      ST_FA_CHK:  cmd.op = OP_WALK_CHK;
      ST_FA_WR:   cmd.op = OP_FA_WR;
      ST_FA_INFO: cmd.op = OP_FA_INFO;
      ST_FB_RD:   cmd.op = OP_WALK_RD;
      ST_FB_CHK:  cmd.op = OP_WALK_CHK;
      ST_FB_WR:   cmd.op = OP_FB_WR;
      ST_FB_INFO: cmd.op = OP_FB_INFO;
      ST_JUDGE:   cmd.op = status.judge_ok ? OP_MERGE : OP_IDLE;
      ST_DIV:     cmd.op = OP_IDLE;
      ST_THR:     cmd.op = OP_THR;
      ST_NEXT:    cmd.op = OP_NEXT;
      ST_O_RD:    cmd.op = OP_WALK_RD;
      ST_O_CHK:   cmd.op = OP_O_CHK;
      ST_O_WAIT:  cmd.op = OP_O_WAIT;
      default:    cmd.op = OP_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/gtc_dp.sv =====
module gtc_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             in_valid,
  input  logic [5:0]       in_node_first,
  input  logic [5:0]       in_node_second,
  input  logic [15:0]      in_weight,
  input  logic             in_last,
  input  logic             out_stall,
  input  gtc_pkg::cmd_t    cmd,
  output gtc_pkg::status_t status,
  output logic             out_valid,
  output logic [5:0]       out_node,
  output logic [5:0]       out_cluster,
  output logic [6:0]       out_set_count,
  output logic             out_edges_dropped,
  output logic             out_final_res
);
  import gtc_pkg::*;

  logic [WGT_W-1:0]     wgt_mem [MAX_EDGES];
  logic [2*NODE_W-1:0]  end_mem [MAX_EDGES];
  logic [EDGE_AW-1:0]   ord_mem [MAX_EDGES];
  logic [NODE_W-1:0]    par_mem [MAX_NODES];
  info_t                info_mem [MAX_NODES];

  logic [CNT_W-1:0]   node_count_r;
  logic [WGT_W-1:0]   scale_c_r;
  logic [TOT_W-1:0]   total_r;
  logic               overflow_r;
  logic               out_valid_r;
  logic [CNT_W-1:0]   sets_left_r;

  logic [EDGE_AW-1:0] i_r, j_r, k_r, cnt_r;
  logic [NODE_W-1:0]  c_r, ni_r, r_r, p_r, q_r, ra_r, rb_r, keep_r;
  logic [WGT_W-1:0]   wi_r, ew_r;
  info_t              ia_r, ib_r;
  logic [RANK_W-1:0]  nrank_r;
  logic [CNT_W-1:0]   nsize_r;

  logic [WGT_W-1:0]    w_rdata;
  logic [2*NODE_W-1:0] e_rdata;
  logic [EDGE_AW-1:0]  ord_rdata;
  logic [NODE_W-1:0]   par_rdata;
  info_t               info_rdata;

  logic [NODE_W-1:0]  out_node_r, out_cluster_r;
  logic [CNT_W-1:0]   out_set_r;
  logic               out_drop_r, out_final_r;

  logic [CNT_W-1:0]   n_eff;
  logic [TOT_W-1:0]   total_m1;
  logic               load_acc;
  logic               out_acc;
  logic               o_last;
  logic [EDGE_AW-1:0] w_raddr;
  logic               par_we;
  logic [NODE_W-1:0]  par_waddr, par_wdata;
  logic               info_we;
  logic [NODE_W-1:0]  info_waddr;
  info_t              info_wdata;
  logic [CNT_W-1:0]   sum_size;
  logic               div_done;
  logic [15:0]        div_q;
  logic [THR_W-1:0]   new_thr;

  assign n_eff = (node_count_r == '0) ? CNT_W'(1) :
                 (node_count_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_r;
  assign total_m1 = total_r - 1'b1;
  assign load_acc = (cmd.op == OP_LOAD) && in_valid;
  assign out_acc  = out_valid_r && !out_stall;
  assign o_last   = ({1'b0, ni_r} == n_eff - 1'b1);
  assign sum_size = ia_r.size + ib_r.size;
  assign new_thr  = {1'b0, ew_r} + {1'b0, div_q};

  always_comb begin
    status.last_acc  = load_acc && in_last;
    status.j_last    = ({1'b0, j_r} == total_m1);
    status.i_last    = ({1'b0, i_r} == total_m1);
    status.clr_last  = (c_r == NODE_W'(MAX_NODES - 1));
    status.range_bad = ({1'b0, e_rdata[2*NODE_W-1:NODE_W]} >= n_eff) ||
                       ({1'b0, e_rdata[NODE_W-1:0]} >= n_eff);
    status.is_root   = (par_rdata == r_r);
    status.judge_ok  = (ra_r != rb_r) && ({1'b0, ew_r} <= ia_r.thr) &&
                       ({1'b0, ew_r} <= ib_r.thr);
    status.div_done  = div_done;
    status.k_last    = ({1'b0, k_r} == total_m1);
    status.o_last    = o_last;
    status.out_acc   = out_acc;
  end

  gtc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_MERGE),
    .dividend (scale_c_r),
    .divisor  (sum_size),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    w_raddr = ord_rdata;
    case (cmd.op)
      OP_RD_WI: w_raddr = i_r;
      OP_RD_WJ: w_raddr = j_r;
      default:  w_raddr = ord_rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_acc && (total_r < TOT_W'(MAX_EDGES))) begin
      wgt_mem[total_r[EDGE_AW-1:0]] <= in_weight;
      end_mem[total_r[EDGE_AW-1:0]] <= {in_node_first, in_node_second};
    end
    w_rdata <= wgt_mem[w_raddr];
    e_rdata <= end_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ORD_WR) begin
      ord_mem[cnt_r] <= i_r;
    end
    ord_rdata <= ord_mem[k_r];
  end

  always_comb begin
    par_we    = 1'b0;
    par_waddr = c_r;
    par_wdata = c_r;
    case (cmd.op)
      OP_CLR: begin
        par_we = 1'b1;
      end
      OP_FA_WR: begin
        par_we    = 1'b1;
        par_waddr = p_r;
        par_wdata = r_r;
      end
      OP_FB_WR: begin
        par_we    = 1'b1;
        par_waddr = q_r;
        par_wdata = r_r;
      end
      OP_MERGE: begin
        par_we = 1'b1;
        if (ia_r.rank > ib_r.rank) begin
          par_waddr = rb_r;
          par_wdata = ra_r;
        end else begin
          par_waddr = ra_r;
          par_wdata = rb_r;
        end
      end
      default: par_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rdata <= par_mem[r_r];
  end

  always_comb begin
    info_we    = 1'b0;
    info_waddr = c_r;
    info_wdata = '{rank: '0, size: CNT_W'(1), thr: {1'b0, scale_c_r}};
    case (cmd.op)
      OP_CLR: info_we = 1'b1;
      OP_THR: begin
        info_we    = 1'b1;
        info_waddr = keep_r;
        info_wdata = '{rank: nrank_r, size: nsize_r, thr: new_thr};
      end
      default: info_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
    info_rdata <= info_mem[r_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(MAX_NODES);
      scale_c_r    <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count_r <= cfg_data[CNT_W-1:0];
        CFG_SCALE_C:    scale_c_r    <= cfg_data;
        default:        scale_c_r    <= scale_c_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_acc) begin
        if (total_r < TOT_W'(MAX_EDGES)) begin
          total_r <= total_r + 1'b1;
        end else begin
          overflow_r <= 1'b1;
        end
      end
      if ((cmd.op == OP_O_CHK) && status.is_root) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
        if (o_last) begin
          total_r    <= '0;
          overflow_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: i_r <= '0;
      OP_RD_WI: begin
        cnt_r <= '0;
        j_r   <= '0;
        c_r   <= '0;
      end
      OP_CAP_WI: wi_r <= w_rdata;
      OP_CMP: begin
        if ((w_rdata < wi_r) || ((w_rdata == wi_r) && (j_r < i_r))) begin
          cnt_r <= cnt_r + 1'b1;
        end
        j_r <= j_r + 1'b1;
      end
      OP_ORD_WR: i_r <= i_r + 1'b1;
      OP_CLR: begin
        c_r         <= c_r + 1'b1;
        k_r         <= '0;
        sets_left_r <= n_eff;
      end
      OP_CAP_EDGE: begin
        ew_r <= w_rdata;
        p_r  <= e_rdata[2*NODE_W-1:NODE_W];
        q_r  <= e_rdata[NODE_W-1:0];
        r_r  <= e_rdata[2*NODE_W-1:NODE_W];
      end
      OP_WALK_CHK: begin
        if (!status.is_root) r_r <= par_rdata;
      end
      OP_FA_WR: ra_r <= r_r;
      OP_FA_INFO: begin
        ia_r <= info_rdata;
        r_r  <= q_r;
      end
      OP_FB_WR: rb_r <= r_r;
      OP_FB_INFO: ib_r <= info_rdata;
      OP_MERGE: begin
        nsize_r <= sum_size;
        if (ia_r.rank > ib_r.rank) begin
          keep_r  <= ra_r;
          nrank_r <= ia_r.rank;
        end else begin
          keep_r  <= rb_r;
          nrank_r <= (ia_r.rank == ib_r.rank) ? ib_r.rank + 1'b1 : ib_r.rank;
        end
        if (sets_left_r != '0) sets_left_r <= sets_left_r - 1'b1;
      end
      OP_NEXT: begin
        k_r  <= k_r + 1'b1;
        ni_r <= '0;
        r_r  <= '0;
      end
      OP_O_CHK: begin
        if (status.is_root) begin
          out_node_r    <= ni_r;
          out_cluster_r <= r_r;
          out_set_r     <= sets_left_r;
          out_drop_r    <= overflow_r;
          out_final_r   <= o_last;
        end else begin
          r_r <= par_rdata;
        end
      end
      OP_O_WAIT: begin
        if (out_acc) begin
          ni_r <= ni_r + 1'b1;
          r_r  <= ni_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_node          = out_node_r;
  assign out_cluster       = out_cluster_r;
  assign out_set_count     = out_set_r;
  assign out_edges_dropped = out_drop_r;
  assign out_final_res     = out_final_r;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_W'(MAX_EDGES)) else $error("edge count above capacity");
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> (total_r == TOT_W'(MAX_EDGES))) else $error("overflow while not full");
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (cmd.op == OP_O_WAIT)) else $error("result shown outside output wait");
`endif

endmodule

// ===== hw/rtl/graph_threshold_clustering.sv =====
// Channel   Direction  Ports                                                 Handshake
// input     in         in_node_first, in_node_second, in_weight, in_last     in_valid / in_stall
// result    out        out_node, out_cluster, out_set_count,                 out_valid / out_stall
//                      out_edges_dropped, out_final_res
// config    in         cfg_we, cfg_index, cfg_data                           write on cfg_we
//
// Edges load at one transaction per cycle; after the last edge a stable rank sort orders
// them by weight, ties by arrival order, and the node table is cleared. Each edge is then
// handled in sorted order: out-of-range endpoints skip it, both roots are found by walking
// parent links, and when two clusters join the serial divider sets the merged threshold.
// Each result walks the parent links of its node and waits out any out_stall; in_stall
// is high from the last edge until the final result transaction. Reset is synchronous.
module graph_threshold_clustering (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_node_first,
  input  logic [5:0]  in_node_second,
  input  logic [15:0] in_weight,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_node,
  output logic [5:0]  out_cluster,
  output logic [6:0]  out_set_count,
  output logic        out_edges_dropped,
  output logic        out_final_res
);
  import gtc_pkg::*;

  cmd_t    cmd;
  status_t status;

  gtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  gtc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_node_first     (in_node_first),
    .in_node_second    (in_node_second),
    .in_weight         (in_weight),
    .in_last           (in_last),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_node          (out_node),
    .out_cluster       (out_cluster),
    .out_set_count     (out_set_count),
    .out_edges_dropped (out_edges_dropped),
    .out_final_res     (out_final_res)
  );

endmodule

// ===== dv/gtc_checker.sv =====
`timescale 1ns / 1ps

module gtc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [5:0]  in_node_first,
  input  logic [5:0]  in_node_second,
  input  logic [15:0] in_weight,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  out_node,
  input  logic [5:0]  out_cluster,
  input  logic [6:0]  out_set_count,
  input  logic        out_edges_dropped,
  input  logic        out_final_res,
  output int          errors,
  output int          pending,
  output int          checked
);
  import gtc_pkg::*;

  typedef struct packed {
    logic [5:0] node;
    logic [5:0] cluster;
    logic [6:0] set_count;
    logic       dropped;
    logic       final_res;
  } label_t;

  label_t expected_labels[$];

  logic [6:0]       node_cfg;
  logic [15:0]      c_cfg;
  logic [15:0]      edge_wt[MAX_EDGES];
  logic [11:0]      edge_nodes[MAX_EDGES];
  int unsigned      edges_held;
  logic             overflowed;

  logic [5:0]       link[MAX_NODES];
  logic [2:0]       rnk[MAX_NODES];
  logic [6:0]       members[MAX_NODES];
  logic [16:0]      limit_thr[MAX_NODES];
  int unsigned      clusters_left;
  int unsigned      sorted_idx[MAX_EDGES];

  function automatic logic [5:0] walk_to_root(logic [5:0] v);
    logic [5:0] r;
    int guard;
    r = v;
    guard = 0;
    while (r != link[r] && guard < MAX_NODES) begin
      r = link[r];
      guard++;
    end
    return r;
  endfunction

  function automatic logic [5:0] root_and_link(logic [5:0] v);
    logic [5:0] r;
    r = walk_to_root(v);
    link[v] = r;
    return r;
  endfunction

  function automatic void cluster_edges();
    int unsigned n, j, e, cur;
    logic [5:0] p, q, ra, rb, keep;
    logic [15:0] ew;
    label_t lb;
    n = node_cfg;
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    for (int unsigned i = 0; i < edges_held; i++) begin
      cur = i;
      j = i;
      while (j > 0 && edge_wt[sorted_idx[j-1]] > edge_wt[cur]) begin
        sorted_idx[j] = sorted_idx[j-1];
        j--;
      end
      sorted_idx[j] = cur;
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      link[i] = 6'(i);
      rnk[i] = '0;
      members[i] = 7'd1;
      limit_thr[i] = {1'b0, c_cfg};
    end
    clusters_left = n;
    for (int unsigned k = 0; k < edges_held; k++) begin
      e = sorted_idx[k];
      p = edge_nodes[e][11:6];
      q = edge_nodes[e][5:0];
      ew = edge_wt[e];
      if (p >= n || q >= n) continue;
      ra = root_and_link(p);
      rb = root_and_link(q);
      if (ra == rb) continue;
      if (ew <= limit_thr[ra] && ew <= limit_thr[rb]) begin
        if (rnk[ra] > rnk[rb]) begin
          link[rb] = ra;
          members[ra] = members[ra] + members[rb];
          keep = ra;
        end else begin
          link[ra] = rb;
          members[rb] = members[rb] + members[ra];
          if (rnk[ra] == rnk[rb]) rnk[rb] = rnk[rb] + 3'd1;
          keep = rb;
        end
        if (clusters_left > 0) clusters_left--;
        keep = root_and_link(keep);
        limit_thr[keep] = {1'b0, ew} + 17'(c_cfg / members[keep]);
      end
    end
    for (int unsigned i = 0; i < n; i++) begin
      lb.node = 6'(i);
      lb.cluster = walk_to_root(6'(i));
      lb.set_count = 7'(clusters_left);
      lb.dropped = overflowed;
      lb.final_res = (i + 1 == n);
      expected_labels.insert(expected_labels.size(), lb);
    end
    edges_held = 0;
    overflowed = 1'b0;
  endfunction

  always @(posedge clk) begin
    label_t got, want;
    if (!rst_n) begin
      node_cfg = 7'd64;
      c_cfg = 16'd256;
      edges_held = 0;
      overflowed = 1'b0;
      expected_labels.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NODE_COUNT: node_cfg = cfg_data[6:0];
          CFG_SCALE_C:    c_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (edges_held < MAX_EDGES) begin
          edge_wt[edges_held] = in_weight;
          edge_nodes[edges_held] = {in_node_first, in_node_second};
          edges_held++;
        end else begin
          overflowed = 1'b1;
        end
        if (in_last) cluster_edges();
      end
      if (out_valid && !out_stall) begin
        got = '{out_node, out_cluster, out_set_count, out_edges_dropped, out_final_res};
        if (expected_labels.size() == 0) begin
          $display("%0t: unexpected result node=%0d cluster=%0d", $time, out_node,
                   out_cluster);
          errors++;
        end else begin
          want = expected_labels.pop_front();
          checked++;
          if (got != want) begin
            $display("%0t: mismatch expected node=%0d cluster=%0d sets=%0d drop=%0b fin=%0b",
                     $time, want.node, want.cluster, want.set_count, want.dropped,
                     want.final_res);
            $display("%0t:          actual   node=%0d cluster=%0d sets=%0d drop=%0b fin=%0b",
                     $time, got.node, got.cluster, got.set_count, got.dropped,
                     got.final_res);
            errors++;
          end
        end
      end
    end
    pending = expected_labels.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import gtc_pkg::*;

  localparam int STALL_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [5:0]  in_node_first;
  logic [5:0]  in_node_second;
  logic [15:0] in_weight;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_node;
  logic [5:0]  out_cluster;
  logic [6:0]  out_set_count;
  logic        out_edges_dropped;
  logic        out_final_res;

  int errors, pending, checked;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit long_hold = 1'b0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  int edges_sent = 0;
  int runs_done = 0;
  int n_now = 64;
  int c_now = 256;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  graph_threshold_clustering u_top (.*);

  gtc_checker u_checker (.*);

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
    end else if (long_hold && hold_cycles < 2000) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      if (!long_hold) hold_cycles <= 0;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NODE_COUNT) begin
      n_now = (value[6:0] < 1) ? 1 : (value[6:0] > 64 ? 64 : value[6:0]);
    end else begin
      c_now = value;
    end
  endtask

  task automatic send_edge(logic [5:0] a, logic [5:0] b, logic [15:0] w, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_node_first <= a;
    in_node_second <= b;
    in_weight <= w;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    edges_sent++;
    if (last) runs_done++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_run(int edges);
    logic [5:0] a, b;
    logic [15:0] w;
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(9) == 0) begin
        a = 6'($urandom);
        b = 6'($urandom);
      end else begin
        a = 6'($urandom_range(n_now - 1));
        b = 6'($urandom_range(n_now - 1));
      end
      if ($urandom_range(9) < 7) begin
        w = 16'($urandom_range((c_now * 3 / 2 > 65535) ? 65535 : c_now * 3 / 2));
      end else begin
        w = 16'($urandom);
      end
      send_edge(a, b, w, i == edges - 1);
    end
  endtask

  task automatic random_settings();
    case ($urandom_range(5))
      0: write_reg(CFG_NODE_COUNT, 16'd1);
      1: write_reg(CFG_NODE_COUNT, 16'd64);
      2: write_reg(CFG_NODE_COUNT, 16'($urandom_range(127)));
      default: write_reg(CFG_NODE_COUNT, 16'($urandom_range(2, 16)));
    endcase
    case ($urandom_range(4))
      0: write_reg(CFG_SCALE_C, 16'd0);
      1: write_reg(CFG_SCALE_C, 16'hFFFF);
      2: write_reg(CFG_SCALE_C, 16'($urandom));
      default: write_reg(CFG_SCALE_C, 16'($urandom_range(64, 2048)));
    endcase
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_NODE_COUNT;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_node_first <= '0;
    in_node_second <= '0;
    in_weight <= '0;
    in_last <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    write_reg(CFG_NODE_COUNT, 16'd8);
    write_reg(CFG_SCALE_C, 16'd256);
    send_edge(6'd0, 6'd1, 16'd0, 1'b0);
    send_edge(6'd1, 6'd2, 16'hFFFF, 1'b0);
    send_edge(6'd3, 6'd3, 16'd5, 1'b0);
    send_edge(6'd2, 6'd9, 16'd1, 1'b0);
    send_edge(6'd4, 6'd5, 16'd100, 1'b0);
    send_edge(6'd5, 6'd6, 16'd100, 1'b0);
    send_edge(6'd63, 6'd0, 16'd2, 1'b0);
    send_edge(6'd6, 6'd7, 16'd256, 1'b1);
    drain();
    write_reg(CFG_NODE_COUNT, 16'd0);
    write_reg(CFG_SCALE_C, 16'd0);
    send_edge(6'd0, 6'd0, 16'd0, 1'b1);
    drain();
    write_reg(CFG_NODE_COUNT, 16'd127);
    write_reg(CFG_SCALE_C, 16'hFFFF);
    send_edge(6'd63, 6'd62, 16'hFFFF, 1'b0);
    send_edge(6'd0, 6'd63, 16'h8000, 1'b0);
    send_edge(6'd21, 6'd42, 16'h5555, 1'b0);
    send_edge(6'd42, 6'd21, 16'hAAAA, 1'b1);
    drain();

    write_reg(CFG_NODE_COUNT, 16'd64);
    write_reg(CFG_SCALE_C, 16'd300);
    random_run(MAX_EDGES + 4);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 84 : 33) : 0;
      stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 84 : 33) : 0;
      for (int r = 0; r < 12; r++) begin
        random_settings();
        random_run($urandom_range(1, 10));
        drain();
      end
    end

    send_idle_pct = 0;
    stall_pct = 20;
    write_reg(CFG_NODE_COUNT, 16'd12);
    write_reg(CFG_SCALE_C, 16'd512);
    long_hold = 1'b1;
    for (int r = 0; r < 4; r++) random_run($urandom_range(3, 8));
    long_hold = 1'b0;
    drain();

    $display("Ran %0d clustering runs from %0d edges, %0d node results checked.",
             runs_done, edges_sent, checked);
    $display("Covered overflow, out-of-range nodes, self edges, clamped node counts and stalls.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
